// ===== hw/rtl/rfps_pkg.sv =====
// Package for the flight phase sequencer: phase encoding, output codes,
// register indexes and reset values. No dependencies.
`default_nettype none

package rfps_pkg;

  // Field widths
  localparam int unsigned ALT_W    = 21;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned DROP_W   = 20;
  localparam int unsigned SPACE_W  = 20;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned PYRO_W   = 4;
  localparam int unsigned TURN_W   = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned IN_W     = 56;  // 53 bits of fields, padded to bytes
  localparam int unsigned OUT_W    = 40;  // 34 bits of fields, padded to bytes

  // Flight phase, one-hot internally
  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_ARMED     = 6'b000010,
    PH_ASCENDING = 6'b000100,
    PH_DROGUE    = 6'b001000,
    PH_MAIN      = 6'b010000,
    PH_LANDED    = 6'b100000
  } phase_t;

  // Phase codes as seen on the output
  localparam logic [CODE_W-1:0] CODE_IDLE      = 3'd0;
  localparam logic [CODE_W-1:0] CODE_ARMED     = 3'd1;
  localparam logic [CODE_W-1:0] CODE_ASCENDING = 3'd2;
  localparam logic [CODE_W-1:0] CODE_DROGUE    = 3'd3;
  localparam logic [CODE_W-1:0] CODE_MAIN      = 3'd4;
  localparam logic [CODE_W-1:0] CODE_LANDED    = 3'd5;

  // Pyro masks
  localparam logic [PYRO_W-1:0] PYRO_NONE   = 4'h0;
  localparam logic [PYRO_W-1:0] PYRO_DROGUE = 4'h3;
  localparam logic [PYRO_W-1:0] PYRO_MAIN   = 4'hC;

  // Turn commands
  localparam logic [TURN_W-1:0] TURN_NONE = 2'd0;
  localparam logic [TURN_W-1:0] TURN_CW   = 2'd1;
  localparam logic [TURN_W-1:0] TURN_CCW  = 2'd2;

  // Turn counter values
  localparam logic [1:0] TURNS_ONE  = 2'd1;
  localparam logic [1:0] TURNS_ALL  = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ARM_DELAY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ASCENT_TRIG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_APOGEE_DROP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_DEPLOY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LANDED_FLR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_SPACE  = 3'd5;

  // Register reset values
  localparam logic [TIME_W-1:0]         RST_ARM_DELAY   = 32'd15000;
  localparam logic signed [ALT_W-1:0]   RST_ASCENT_TRIG = 21'sd200;
  localparam logic [DROP_W-1:0]         RST_APOGEE_DROP = 20'd50;
  localparam logic signed [ALT_W-1:0]   RST_MAIN_DEPLOY = 21'sd3000;
  localparam logic signed [ALT_W-1:0]   RST_LANDED_FLR  = 21'sd50;
  localparam logic [SPACE_W-1:0]        RST_TURN_SPACE  = 20'd5000;

  function automatic logic [CODE_W-1:0] phase_code(input phase_t p);
    logic [CODE_W-1:0] c;
    case (p)
      PH_IDLE:      c = CODE_IDLE;
      PH_ARMED:     c = CODE_ARMED;
      PH_ASCENDING: c = CODE_ASCENDING;
      PH_DROGUE:    c = CODE_DROGUE;
      PH_MAIN:      c = CODE_MAIN;
      PH_LANDED:    c = CODE_LANDED;
      default:      c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rocket_flight_phase_sequencer_unit.sv =====
// Flight phase sequencer top level: input register, phase/apogee/turn logic,
// result register. Depends on rfps_pkg.
`default_nettype none

// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tdata: altitude_dm[20:0], time_ms[52:21]
// m_*       out  m_tvalid/m_tready    tdata: flight_phase, phase_changed, pyro,
//                                     turn, wheel, fast log, aux log, apogee
// cfg_*     in   cfg_we (no wait)     cfg_index selects register, cfg_data value
//
// Accept to result passes through the input register, then the result register.
// Throughput: one item per cycle unless a held result stalls; the flight state updates as an item moves
// from the input register into the result register.
// Stalls: a held result blocks the input register; s_tready follows it.
// Reset (rst, synchronous): phase idle, apogee 0, logging aux on, config to
// defaults. No clearing pass.

module rocket_flight_phase_sequencer_unit
  import rfps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input items
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [IN_W-1:0]      s_tdata,   // altitude_dm[20:0], time_ms[52:21], pad
  // result items
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [OUT_W-1:0]          m_tdata,   // flight_phase[2:0], phase_changed[3],
                                               // pyro_fire_mask[7:4], turn_command[9:8],
                                               // wheel_enable[10], fast_logging[11],
                                               // aux_logging[12], apogee_dm[33:13], pad
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  // ---------------- configuration registers ----------------
  logic [TIME_W-1:0]       arm_delay;
  logic signed [ALT_W-1:0] ascent_trig;
  logic [DROP_W-1:0]       apogee_drop;
  logic signed [ALT_W-1:0] main_deploy;
  logic signed [ALT_W-1:0] landed_floor;
  logic [SPACE_W-1:0]      turn_space;

  always_ff @(posedge clk) begin
    if (rst) begin
      arm_delay    <= RST_ARM_DELAY;
      ascent_trig  <= RST_ASCENT_TRIG;
      apogee_drop  <= RST_APOGEE_DROP;
      main_deploy  <= RST_MAIN_DEPLOY;
      landed_floor <= RST_LANDED_FLR;
      turn_space   <= RST_TURN_SPACE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ARM_DELAY:   arm_delay    <= cfg_data[TIME_W-1:0];
        REG_ASCENT_TRIG: ascent_trig  <= $signed(cfg_data[ALT_W-1:0]);
        REG_APOGEE_DROP: apogee_drop  <= cfg_data[DROP_W-1:0];
        REG_MAIN_DEPLOY: main_deploy  <= $signed(cfg_data[ALT_W-1:0]);
        REG_LANDED_FLR:  landed_floor <= $signed(cfg_data[ALT_W-1:0]);
        REG_TURN_SPACE:  turn_space   <= cfg_data[SPACE_W-1:0];
        default: ;  // out-of-range index: ignored
      endcase
    end
  end

  // ---------------- handshake / pipeline control ----------------
  logic                    in_valid;
  logic signed [ALT_W-1:0] in_alt;
  logic [TIME_W-1:0]       in_time;
  logic                    out_free;
  logic                    advance;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_alt  <= $signed(s_tdata[ALT_W-1:0]);
      in_time <= s_tdata[ALT_W +: TIME_W];
    end
  end

  // ---------------- flight state ----------------
  phase_t                  phase, phase_next;
  logic signed [ALT_W-1:0] apogee, apogee_next;
  logic [TIME_W-1:0]       deploy_time, deploy_time_next;
  logic [1:0]              turns_done, turns_done_next;
  logic                    parafoil_active, parafoil_active_next;
  logic                    wheel_on, wheel_on_next;
  logic                    fast_log, fast_log_next;
  logic                    aux_log, aux_log_next;

  logic signed [ALT_W-1:0] apogee_max;
  logic signed [ALT_W+1:0] alt_ext;
  logic signed [ALT_W+1:0] drop_limit;   // apogee - drop, full precision
  logic                    changed;
  logic [PYRO_W-1:0]       pyro;
  logic [TURN_W-1:0]       turn;
  logic [SPACE_W+1:0]      turn_offset;  // k * spacing, k = 1..3
  logic [TIME_W:0]         turn_due;
  logic                    turn_fire;

  // running maximum first
  assign apogee_max = (in_alt > apogee) ? in_alt : apogee;
  assign alt_ext    = {{2{in_alt[ALT_W-1]}}, in_alt};
  assign drop_limit = $signed({{2{apogee_max[ALT_W-1]}}, apogee_max})
                    - $signed({3'b000, apogee_drop});

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE:      if (in_time > arm_delay)        phase_next = PH_ARMED;
      PH_ARMED:     if (in_alt > ascent_trig)       phase_next = PH_ASCENDING;
      PH_ASCENDING: if (alt_ext < drop_limit)       phase_next = PH_DROGUE;
      PH_DROGUE:    if (in_alt < main_deploy)       phase_next = PH_MAIN;
      PH_MAIN:      if (in_alt < landed_floor)      phase_next = PH_LANDED;
      PH_LANDED:    phase_next = PH_LANDED;
      default:      phase_next = PH_IDLE;
    endcase
  end

  assign changed = (phase_next != phase);

  // entry actions
  always_comb begin
    apogee_next          = apogee_max;
    deploy_time_next     = deploy_time;
    parafoil_active_next = parafoil_active;
    wheel_on_next        = wheel_on;
    fast_log_next        = fast_log;
    aux_log_next         = aux_log;
    pyro                 = PYRO_NONE;
    if (changed) begin
      case (phase_next)
        PH_ARMED: begin
          apogee_next   = '0;
          fast_log_next = 1'b1;
          aux_log_next  = 1'b0;
        end
        PH_ASCENDING: wheel_on_next = 1'b1;
        PH_DROGUE: begin
          wheel_on_next = 1'b0;
          pyro          = PYRO_DROGUE;
        end
        PH_MAIN: begin
          parafoil_active_next = 1'b1;
          deploy_time_next     = in_time;
          pyro                 = PYRO_MAIN;
        end
        PH_LANDED: begin
          parafoil_active_next = 1'b0;
          fast_log_next        = 1'b0;
          aux_log_next         = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Turn schedule. Only live while already in main and staying there: on the
  // main entry tick parafoil_active is still clear, and on the landing tick the
  // phase change itself holds the turn off.
  always_comb begin
    case (turns_done)
      2'd0:    turn_offset = {2'b00, turn_space};
      2'd1:    turn_offset = {1'b0, turn_space, 1'b0};
      default: turn_offset = {2'b00, turn_space} + {1'b0, turn_space, 1'b0};
    endcase
  end

  assign turn_due  = {1'b0, deploy_time} + {{(TIME_W-SPACE_W-1){1'b0}}, turn_offset};
  assign turn_fire = parafoil_active && !changed && (turns_done != TURNS_ALL)
                  && ({1'b0, in_time} > turn_due);
  assign turn      = !turn_fire ? TURN_NONE
                   : (turns_done == TURNS_ONE) ? TURN_CCW : TURN_CW;
  assign turns_done_next = turn_fire ? turns_done + 2'd1 : turns_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      apogee          <= '0;
      deploy_time     <= '0;
      turns_done      <= '0;
      parafoil_active <= 1'b0;
      wheel_on        <= 1'b0;
      fast_log        <= 1'b0;
      aux_log         <= 1'b1;
    end else if (advance) begin
      phase           <= phase_next;
      apogee          <= apogee_next;
      deploy_time     <= deploy_time_next;
      turns_done      <= turns_done_next;
      parafoil_active <= parafoil_active_next;
      wheel_on        <= wheel_on_next;
      fast_log        <= fast_log_next;
      aux_log         <= aux_log_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {6'b000000, apogee_next, aux_log_next, fast_log_next, wheel_on_next,
                  turn, pyro, changed, phase_code(phase_next)};
    end
  end

  // ---------------- assertions ----------------
  // Pyro channels only fire on a phase entry.
  a_pyro_on_entry: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[7:4] != PYRO_NONE)) |-> m_tdata[3])
    else $error("pyro fired without a phase change");

  // Turns only go out while the phase is main.
  a_turn_in_main: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[9:8] != TURN_NONE)) |-> (m_tdata[2:0] == CODE_MAIN))
    else $error("turn command outside main phase");

  // Before arming, logging sits in its reset mode.
  a_idle_logging: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (!fast_log && aux_log && !parafoil_active))
    else $error("logging or parafoil state wrong in idle");

  // The parafoil is active only while in main.
  a_parafoil_main: assert property (@(posedge clk) disable iff (rst)
    parafoil_active |-> (phase == PH_MAIN))
    else $error("parafoil active outside main");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for the rocket flight phase sequencer: flies one full
// flight (idle to landed) with register changes between batches of sensor ticks.
// Depends on rfps_pkg and rocket_flight_phase_sequencer_unit.
`timescale 1ns / 1ps

module testbench;
  import rfps_pkg::*;

  localparam int ALT_MIN     = -100000;
  localparam int ALT_MAX     = 1000000;
  localparam int FULL_MIN    = -1048576;       // 21-bit signed extremes
  localparam int FULL_MAX    = 1048575;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [TIME_W-1:0] WRAP_DEPLOY = 32'hFFFF_F000;  // deploy close to wrap
  localparam logic [CFG_IDX_W-1:0] REG_VOID_LO = 3'd6;        // past the last register
  localparam logic [CFG_IDX_W-1:0] REG_VOID_HI = 3'd7;

  // One sensor tick as it travels on s_tdata
  typedef struct packed {
    logic [TIME_W-1:0]       time_ms;
    logic signed [ALT_W-1:0] alt;
  } sensor_tick_t;

  // One result; bit order matches m_tdata[33:0]
  typedef struct packed {
    logic signed [ALT_W-1:0] apogee;
    logic                    aux;
    logic                    fast;
    logic                    wheel;
    logic [TURN_W-1:0]       turn;
    logic [PYRO_W-1:0]       pyro;
    logic                    changed;
    logic [CODE_W-1:0]       code;
  } flight_result_t;

  typedef enum {TRAFFIC_STEADY, TRAFFIC_SPARSE_IN, TRAFFIC_SLOW_OUT, TRAFFIC_MIXED} traffic_t;

  logic clk;
  logic rst = 1'b1;

  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata   = '0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ARM_DELAY;
  logic [CFG_W-1:0]  cfg_data  = '0;

  // Register shadow, at reset values
  logic [TIME_W-1:0]       c_arm   = RST_ARM_DELAY;
  logic signed [ALT_W-1:0] c_trig  = RST_ASCENT_TRIG;
  logic [DROP_W-1:0]       c_drop  = RST_APOGEE_DROP;
  logic signed [ALT_W-1:0] c_main  = RST_MAIN_DEPLOY;
  logic signed [ALT_W-1:0] c_floor = RST_LANDED_FLR;
  logic [SPACE_W-1:0]      c_space = RST_TURN_SPACE;

  // Predicted flight state
  logic [CODE_W-1:0]       fp_phase  = CODE_IDLE;
  logic signed [ALT_W-1:0] fp_apogee = '0;
  logic [TIME_W-1:0]       fp_deploy = '0;
  logic [1:0]              fp_turns  = '0;
  logic                    fp_para   = 1'b0;
  logic                    fp_wheel  = 1'b0;
  logic                    fp_fast   = 1'b0;
  logic                    fp_aux    = 1'b1;

  sensor_tick_t   tick_q[$];      // ticks waiting for the driver
  flight_result_t result_q[$];    // predicted results, oldest first
  sensor_tick_t   next_tick;

  traffic_t traffic       = TRAFFIC_STEADY;
  int       send_idle_pct = 0;
  int       stall_pct     = 0;
  int       mismatches    = 0;
  int       cycle_count   = 0;
  int       ap;                   // apogee as the stimulus sees it during ascent

  rocket_flight_phase_sequencer_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),     // altitude_dm[20:0], time_ms[52:21], pad
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),     // flight_phase[2:0], phase_changed[3], pyro_fire_mask[7:4],
                              // turn_command[9:8], wheel_enable[10], fast_logging[11],
                              // aux_logging[12], apogee_dm[33:13], pad
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Flight predictor: apogee first, at most one phase step, then at most one turn.
  function automatic flight_result_t advance_flight(logic signed [ALT_W-1:0] alt,
                                                    logic [TIME_W-1:0] now);
    flight_result_t r;
    logic [CODE_W-1:0] nxt;
    logic [63:0] due;
    r = '0;
    r.pyro = PYRO_NONE;
    r.turn = TURN_NONE;
    nxt = fp_phase;
    if (alt > fp_apogee) fp_apogee = alt;
    case (fp_phase)
      CODE_IDLE:      if (now > c_arm) nxt = CODE_ARMED;
      CODE_ARMED:     if (alt > c_trig) nxt = CODE_ASCENDING;
      // full precision: the drop can never wrap the threshold
      CODE_ASCENDING: if (longint'(alt) < longint'(fp_apogee) - longint'(c_drop))
                        nxt = CODE_DROGUE;
      CODE_DROGUE:    if (alt < c_main) nxt = CODE_MAIN;
      CODE_MAIN:      if (alt < c_floor) nxt = CODE_LANDED;
      default: ;
    endcase
    if (nxt != fp_phase) begin
      r.changed = 1'b1;
      case (nxt)
        CODE_ARMED: begin
          fp_fast = 1'b1;
          fp_aux = 1'b0;
          fp_apogee = '0;
        end
        CODE_ASCENDING: fp_wheel = 1'b1;
        CODE_DROGUE: begin
          fp_wheel = 1'b0;
          r.pyro = PYRO_DROGUE;
        end
        CODE_MAIN: begin
          fp_para = 1'b1;
          fp_deploy = now;
          r.pyro = PYRO_MAIN;
        end
        CODE_LANDED: begin
          fp_para = 1'b0;
          fp_fast = 1'b0;
          fp_aux = 1'b1;
        end
        default: ;
      endcase
    end
    fp_phase = nxt;
    // due times are 64-bit: a due time past 2^32 is simply never reached
    if (fp_para && fp_turns != TURNS_ALL) begin
      due = 64'(fp_deploy) + (64'(fp_turns) + 64'd1) * 64'(c_space);
      if (64'(now) > due) begin
        r.turn = (fp_turns == TURNS_ONE) ? TURN_CCW : TURN_CW;
        fp_turns = fp_turns + 2'd1;
      end
    end
    r.code   = fp_phase;
    r.wheel  = fp_wheel;
    r.fast   = fp_fast;
    r.aux    = fp_aux;
    r.apogee = fp_apogee;
    return r;
  endfunction

  task automatic flag_field(string field, longint unsigned want, longint unsigned got);
    $display("%0t mismatch on %s: expected %0h, actual %0h", $time, field, want, got);
    mismatches++;
  endtask

  task automatic check_result(flight_result_t got);
    flight_result_t want;
    if (result_q.size() == 0) begin
      $display("%0t result with nothing expected: expected none, actual %h", $time, got);
      mismatches++;
    end else begin
      want = result_q.pop_front();
      if (got.code !== want.code)       flag_field("flight_phase", want.code, got.code);
      if (got.changed !== want.changed) flag_field("phase_changed", want.changed, got.changed);
      if (got.pyro !== want.pyro)       flag_field("pyro_fire_mask", want.pyro, got.pyro);
      if (got.turn !== want.turn)       flag_field("turn_command", want.turn, got.turn);
      if (got.wheel !== want.wheel)     flag_field("wheel_enable", want.wheel, got.wheel);
      if (got.fast !== want.fast)       flag_field("fast_logging", want.fast, got.fast);
      if (got.aux !== want.aux)         flag_field("aux_logging", want.aux, got.aux);
      if (got.apogee !== want.apogee)   flag_field("apogee_dm", want.apogee, got.apogee);
    end
  endtask

  // Driver: predicts on every accepted item, then holds, loads or idles.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        result_q.push_back(advance_flight(s_tdata[ALT_W-1:0], s_tdata[ALT_W+TIME_W-1:ALT_W]));
      if (!s_tvalid || s_tready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_tick = tick_q.pop_front();
          s_tdata  <= {{(IN_W-ALT_W-TIME_W){1'b0}}, next_tick.time_ms, next_tick.alt};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks accepted results, stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result(flight_result_t'(m_tdata[33:0]));
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic logic [TIME_W-1:0] rand_time(logic [TIME_W-1:0] t_max);
    return (t_max == 32'hFFFF_FFFF) ? $urandom() : $urandom_range(t_max);
  endfunction

  task automatic push_tick(int alt, logic [TIME_W-1:0] now);
    sensor_tick_t t;
    t.alt = alt[ALT_W-1:0];
    t.time_ms = now;
    tick_q.push_back(t);
  endtask

  task automatic fly(int n, int lo, int hi, logic [TIME_W-1:0] t_max);
    repeat (n) push_tick(rand_between(lo, hi), rand_time(t_max));
  endtask

  // Ascent profile: climbs in random steps, never drops past the apogee drop.
  task automatic climb(int n);
    int lo_b, hi_b, alt;
    repeat (n) begin
      lo_b = ap - int'(c_drop);
      if (lo_b < ALT_MIN) lo_b = ALT_MIN;
      hi_b = ap + 20000;
      if (hi_b > FULL_MAX) hi_b = FULL_MAX;
      alt = rand_between(lo_b, hi_b);
      if (alt > ap) ap = alt;
      push_tick(alt, $urandom());
    end
  endtask

  // Register write; the block is idle whenever this is called.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_ARM_DELAY:   c_arm   = data;
      REG_ASCENT_TRIG: c_trig  = data[ALT_W-1:0];
      REG_APOGEE_DROP: c_drop  = data[DROP_W-1:0];
      REG_MAIN_DEPLOY: c_main  = data[ALT_W-1:0];
      REG_LANDED_FLR:  c_floor = data[ALT_W-1:0];
      REG_TURN_SPACE:  c_space = data[SPACE_W-1:0];
      default: ;  // no such register, write dropped
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Lets the queued ticks drain completely, then moves to the next traffic pattern.
  // Polled on the falling edge so the driver and monitor updates have settled.
  task automatic settle();
    while (tick_q.size() != 0 || s_tvalid || result_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);  // margin for the input and result registers to drain
    traffic = traffic.next();
    case (traffic)
      TRAFFIC_STEADY:    begin send_idle_pct = 0;  stall_pct = 0;  end
      TRAFFIC_SPARSE_IN: begin send_idle_pct = 75; stall_pct = 0;  end
      TRAFFIC_SLOW_OUT:  begin send_idle_pct = 0;  stall_pct = 75; end
      default:           begin send_idle_pct = 38; stall_pct = 38; end
    endcase
  endtask

  // Stimulus: one flight, each phase held for a while, registers changed between batches.
  initial begin : stimulus
    int thr;
    logic [TIME_W-1:0] t_arm;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Idle. Arm delay at max means no timestamp can arm; field extremes.
    write_reg(REG_ARM_DELAY, 32'hFFFF_FFFF);
    write_reg(REG_VOID_LO, 32'hFFFF_FFFF);
    write_reg(REG_VOID_HI, 32'h0000_0001);
    push_tick(FULL_MIN, 32'd0);
    push_tick(FULL_MAX, 32'hFFFF_FFFF);
    push_tick(ALT_MIN, 32'd1);
    push_tick(ALT_MAX, 32'h8000_0000);
    push_tick(0, 32'h7FFF_FFFF);
    push_tick(-1, 32'h5555_5555);
    push_tick(1, 32'hAAAA_AAAA);
    settle();
    // zero delay: a timestamp of zero is not past it
    write_reg(REG_ARM_DELAY, 32'd0);
    push_tick(rand_between(FULL_MIN, FULL_MAX), 32'd0);
    settle();
    t_arm = 32'hFFFF_0000 + $urandom_range(16'hFFFE);
    write_reg(REG_ARM_DELAY, t_arm);
    repeat (2) begin
      fly(60, FULL_MIN, FULL_MAX, t_arm);
      settle();
    end
    push_tick(rand_between(FULL_MIN, FULL_MAX), t_arm);
    push_tick(rand_between(FULL_MIN, FULL_MAX), t_arm + 32'd1);   // arms
    settle();

    // Armed. Trigger at the top of the signed range, high bits of the write set.
    write_reg(REG_ASCENT_TRIG, 32'hA5EF_FFFF);
    fly(60, FULL_MIN, FULL_MAX, 32'hFFFF_FFFF);
    settle();
    write_reg(REG_ASCENT_TRIG, ALT_MIN);
    push_tick(ALT_MIN, $urandom());
    push_tick(FULL_MIN, $urandom());
    push_tick(ALT_MIN - 1, $urandom());
    settle();
    thr = rand_between(0, 500000);
    write_reg(REG_ASCENT_TRIG, thr);
    repeat (2) begin
      fly(40, ALT_MIN, thr, 32'hFFFF_FFFF);
      settle();
    end
    push_tick(thr, $urandom());
    push_tick(thr + 1, $urandom());                                // lift-off
    settle();

    // Ascending. Largest drop, no drop, then ordinary drops.
    ap = fp_apogee;
    write_reg(REG_APOGEE_DROP, 32'hFFFF_FFFF);
    climb(50);
    settle();
    write_reg(REG_APOGEE_DROP, 32'd0);
    climb(30);
    settle();
    write_reg(REG_APOGEE_DROP, rand_between(1, 5000));
    repeat (2) begin
      climb(50);
      settle();
    end
    push_tick(ap - int'(c_drop), $urandom());                      // exactly at the drop
    push_tick(ap - int'(c_drop) - 1, $urandom());                  // apogee, drogue fires
    settle();

    // Drogue. Main deploy at both extremes, then a random altitude.
    write_reg(REG_MAIN_DEPLOY, ALT_MIN);
    write_reg(REG_LANDED_FLR, ALT_MIN);
    write_reg(REG_TURN_SPACE, 32'hFFFF_FFFF);
    fly(40, ALT_MIN, FULL_MAX, 32'hFFFF_FFFF);
    settle();
    write_reg(REG_MAIN_DEPLOY, ALT_MAX);
    fly(30, ALT_MAX, FULL_MAX, 32'hFFFF_FFFF);
    settle();
    thr = rand_between(0, 500000);
    write_reg(REG_MAIN_DEPLOY, thr);
    fly(40, thr, ALT_MAX, 32'hFFFF_FFFF);
    push_tick(thr, $urandom());
    push_tick(thr - 1, WRAP_DEPLOY);                               // main fires near wrap
    settle();

    // Main. Largest spacing puts every turn past 2^32: none may come.
    fly(40, ALT_MIN, FULL_MAX, 32'hFFFF_FFFF);
    push_tick(rand_between(ALT_MIN, FULL_MAX), 32'hFFFF_FFFF);
    settle();
    // zero spacing: all three due at once, only the first goes out
    write_reg(REG_TURN_SPACE, 32'd0);
    push_tick(rand_between(ALT_MIN, FULL_MAX), WRAP_DEPLOY);
    push_tick(rand_between(ALT_MIN, FULL_MAX), WRAP_DEPLOY + 32'd1);
    settle();
    write_reg(REG_TURN_SPACE, 32'd1000);
    push_tick(rand_between(ALT_MIN, FULL_MAX), WRAP_DEPLOY + 32'd2000);
    push_tick(rand_between(ALT_MIN, FULL_MAX), WRAP_DEPLOY + 32'd2001);  // second turn
    settle();
    // third turn held off: timestamps stay at or below its due time
    write_reg(REG_LANDED_FLR, ALT_MAX);
    fly(20, ALT_MAX, FULL_MAX, WRAP_DEPLOY + 32'd3000);
    settle();
    thr = rand_between(0, 500000);
    write_reg(REG_LANDED_FLR, thr);
    fly(40, thr, ALT_MAX, WRAP_DEPLOY + 32'd3000);
    push_tick(thr, WRAP_DEPLOY + 32'd3000);
    push_tick(thr - 1, 32'hFFFF_FFFF);                             // lands with a turn due
    settle();

    // Landed: final phase; only the apogee may still move.
    repeat (4) begin
      write_reg(REG_ARM_DELAY, $urandom());
      write_reg(REG_ASCENT_TRIG, $urandom());
      write_reg(REG_APOGEE_DROP, $urandom());
      write_reg(REG_MAIN_DEPLOY, $urandom());
      write_reg(REG_LANDED_FLR, $urandom());
      write_reg(REG_TURN_SPACE, $urandom_range(1));
      write_reg(REG_VOID_HI, $urandom());
      fly(60, FULL_MIN, FULL_MAX, 32'hFFFF_FFFF);
      settle();
    end

    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rfps_pkg.sv
hw/rtl/rocket_flight_phase_sequencer_unit.sv
tb/testbench.sv
